// ===== design/wssa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssa_pkg
// Shared types and constants of the spectrum scatter-accumulate block.
// ----------------------------------------------------------------------------
package wssa_pkg;

  localparam int unsigned CubeDepthDef   = 4096;
  localparam int unsigned MaxOutChanDef  = 256;
  localparam int unsigned SumW           = 48;
  localparam int unsigned CntW           = 40;

  localparam logic [1:0] ModeNone   = 2'd0;
  localparam logic [1:0] ModeSpread = 2'd1;
  localparam logic [1:0] ModeInVar  = 2'd2;

  localparam logic [12:0] PlaneReset = 13'd64;

  // input transaction fields
  typedef struct packed {
    logic               func;
    logic signed [31:0] sample;
    logic               sample_bad;
    logic [7:0]         out_chan;
    logic               out_chan_valid;
    logic [11:0]        spatial_pos;
    logic [15:0]        weight;
    logic [31:0]        input_variance;
    logic               last;
    logic [11:0]        cell_addr;
  } item_t;

  // result fields
  typedef struct packed {
    logic [47:0] data_sum;
    logic [47:0] weight_sum;
    logic [47:0] var_sum;
    logic [47:0] square_sum;
    logic        spectrum_used;
    logic [39:0] used_count;
    logic        addr_error;
  } result_t;

endpackage

// ===== design/wssa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module wssa_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== design/wssa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssa_front
// Accepts items, computes the cell index and classifies each item.
// ----------------------------------------------------------------------------
module wssa_front #(
  parameter int unsigned CubeDepth  = wssa_pkg::CubeDepthDef,
  parameter int unsigned MaxOutChan = wssa_pkg::MaxOutChanDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wssa_pkg::item_t   item_i,
  input  logic [12:0]       plane_size_i,
  output logic              q_valid_o,
  input  logic              q_ready_i,
  output wssa_pkg::item_t   q_item_o,
  output logic [$clog2(CubeDepth)-1:0] q_cell_o,
  output logic              q_use_o,
  output logic              q_err_o
);
  import wssa_pkg::*;
  localparam int unsigned AW = $clog2(CubeDepth);

  logic        valid_q;
  item_t       item_q;
  logic [AW-1:0] cell_q;
  logic        use_q, err_q;
  logic [21:0] cell_full;
  logic        mapped, in_cube, rd_in;

  // cell index and classification
  always_comb begin
    cell_full = 22'(item_i.spatial_pos) + 22'(item_i.out_chan) * 22'(plane_size_i);
    mapped    = !item_i.sample_bad && item_i.out_chan_valid &&
                (32'(item_i.out_chan) < MaxOutChan);
    in_cube   = (32'(cell_full) < CubeDepth);
    rd_in     = (32'(item_i.cell_addr) < CubeDepth);
  end

  assign in_ready_o = !valid_q || q_ready_i;
  assign q_valid_o  = valid_q;
  assign q_item_o   = item_q;
  assign q_cell_o   = cell_q;
  assign q_use_o    = use_q;
  assign q_err_o    = err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
      if (item_i.func) begin
        cell_q <= AW'(item_i.cell_addr);
        use_q  <= rd_in;
        err_q  <= 1'b0;
      end else begin
        cell_q <= AW'(cell_full);
        use_q  <= mapped && in_cube;
        err_q  <= mapped && !in_cube;
      end
    end
  end
endmodule

// ===== design/wssa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wssa_back
// Read-modify-write sequencer over the four cell stores, with clearing pass.
// ----------------------------------------------------------------------------
module wssa_back #(
  parameter int unsigned CubeDepth = wssa_pkg::CubeDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_ready_o,
  input  wssa_pkg::item_t   q_item_i,
  input  logic [$clog2(CubeDepth)-1:0] q_cell_i,
  input  logic              q_use_i,
  input  logic              q_err_i,
  input  logic [1:0]        var_mode_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wssa_pkg::result_t out_o
);
  import wssa_pkg::*;
  localparam int unsigned AW = $clog2(CubeDepth);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0]    st_q, st_d;
  logic [AW:0]   clr_q;
  item_t         it_q;
  logic [AW-1:0] cell_q;
  logic          use_q, err_q;
  logic          sused_q, aerr_q;
  logic [39:0]   cnt_q;
  result_t       res_q;
  logic          ov_q;

  logic          we;
  logic [AW-1:0] addr;
  logic [47:0]   wd_d, wd_w, wd_v, wd_s, rd_d, rd_w, rd_v, rd_s;

  // read data captured after the access cycle
  logic [47:0] rd_d_hold, rd_w_hold, rd_v_hold, rd_s_hold;

  // products, registered before accumulation
  logic signed [47:0] p_data_q;
  logic [31:0]        p_ww_q;
  logic [63:0]        p_s2_q;
  logic [47:0]        p_var_q;
  logic [47:0]        p_sq_q;
  logic [31:0]        mag;
  logic [47:0]        p_var_add;
  logic [71:0]        p_var_full;
  logic [71:0]        p_sq_full;
  logic [47:0]        p_sq_add;
  logic [48:0]        usum_w, usum_v, usum_s;
  logic signed [48:0] ssum;

  function automatic logic [31:0] q_item_w_mag(input logic signed [31:0] s);
    return s[31] ? 32'(-s) : 32'(s);
  endfunction

  assign mag = q_item_w_mag(it_q.sample);

  always_ff @(posedge clk_i) begin
    if (st_q == StRead) begin
      p_data_q <= 48'(it_q.sample) * $signed({1'b0, it_q.weight});
      p_ww_q   <= 32'(it_q.weight) * 32'(it_q.weight);
      p_s2_q   <= 64'(mag) * 64'(mag);
    end
    if (st_q == StMul) begin
      p_var_q <= p_var_add;
      p_sq_q  <= p_sq_add;
    end
  end

  // second-level products (StMul); the square product is clamped to the sum range
  always_comb begin
    p_var_full = 72'(p_ww_q) * 72'(it_q.input_variance);
    p_sq_full  = ((72'(p_s2_q[63:32]) * 72'(it_q.weight)) << 8) +
                 ((72'(p_s2_q[31:0]) * 72'(it_q.weight)) >> 24);
    p_sq_add   = (|p_sq_full[71:48]) ? {48{1'b1}} : p_sq_full[47:0];
    p_var_add  = p_var_full[63:16];
  end

  // saturating adds (StAdd)
  always_comb begin
    ssum   = 49'($signed(rd_d)) + 49'(p_data_q);
    usum_w = 49'(rd_w) + 49'(it_q.weight);
    usum_v = 49'(rd_v) + ((var_mode_i == ModeSpread) ? 49'(p_ww_q) :
                          (var_mode_i == ModeInVar) ? 49'(p_var_q) : 49'd0);
    usum_s = 49'(rd_s) + ((var_mode_i == ModeSpread) ? 49'(p_sq_q) : 49'd0);
  end

  always_comb begin
    we   = 1'b0;
    addr = cell_q;
    wd_d = 48'd0; wd_w = 48'd0; wd_v = 48'd0; wd_s = 48'd0;
    if (st_q == StClear) begin
      we   = 1'b1;
      addr = clr_q[AW-1:0];
    end else if (st_q == StAdd && use_q && !it_q.func) begin
      we   = 1'b1;
      wd_d = (ssum[48] != ssum[47]) ? (ssum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                                    : ssum[47:0];
      wd_w = usum_w[48] ? {48{1'b1}} : usum_w[47:0];
      wd_v = usum_v[48] ? {48{1'b1}} : usum_v[47:0];
      wd_s = usum_s[48] ? {48{1'b1}} : usum_s[47:0];
    end
  end

  wssa_ram #(.Width(SumW), .Depth(CubeDepth)) u_data (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wd_d), .rdata_o(rd_d));
  wssa_ram #(.Width(SumW), .Depth(CubeDepth)) u_wght (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wd_w), .rdata_o(rd_w));
  wssa_ram #(.Width(SumW), .Depth(CubeDepth)) u_var (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wd_v), .rdata_o(rd_v));
  wssa_ram #(.Width(SumW), .Depth(CubeDepth)) u_sq (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wd_s), .rdata_o(rd_s));

  assign q_ready_o   = (st_q == StIdle);
  assign out_valid_o = ov_q;
  assign out_o       = res_q;

  // sequencer
  always_comb begin
    st_d = st_q;
    case (st_q)
      StClear: if (clr_q == (AW+1)'(CubeDepth - 1)) st_d = StIdle;
      StIdle:  if (q_valid_i) st_d = StRead;
      StRead:  st_d = StMul;
      StMul:   st_d = StAdd;
      StAdd:   st_d = StOut;
      StOut:   if (!ov_q || out_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StClear;
      clr_q   <= '0;
      sused_q <= 1'b0;
      aerr_q  <= 1'b0;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == StClear) clr_q <= clr_q + (AW+1)'(1);
      // result valid: set on delivery of a read or a last paste item, cleared when taken
      if (st_q == StOut && (!ov_q || out_ready_i) && (it_q.func || it_q.last)) begin
        ov_q <= 1'b1;
      end else if (ov_q && out_ready_i) begin
        ov_q <= 1'b0;
      end
      if (st_q == StAdd && !it_q.func) begin
        if (use_q) begin
          sused_q <= 1'b1;
          cnt_q   <= cnt_q + 40'd1;
        end
        if (err_q) aerr_q <= 1'b1;
      end
      if (st_q == StOut && (!ov_q || out_ready_i) && !it_q.func && it_q.last) begin
        sused_q <= 1'b0;
        aerr_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_valid_i) begin
      it_q   <= q_item_i;
      cell_q <= q_cell_i;
      use_q  <= q_use_i;
      err_q  <= q_err_i;
    end
    if (st_q == StOut && (!ov_q || out_ready_i)) begin
      res_q.data_sum      <= (it_q.func && use_q) ? rd_d_hold : 48'd0;
      res_q.weight_sum    <= (it_q.func && use_q) ? rd_w_hold : 48'd0;
      res_q.var_sum       <= (it_q.func && use_q) ? rd_v_hold : 48'd0;
      res_q.square_sum    <= (it_q.func && use_q) ? rd_s_hold : 48'd0;
      res_q.spectrum_used <= sused_q;
      res_q.used_count    <= cnt_q;
      res_q.addr_error    <= aerr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StMul) begin
      rd_d_hold <= rd_d; rd_w_hold <= rd_w; rd_v_hold <= rd_v; rd_s_hold <= rd_s;
    end
  end
endmodule

// ===== design/weighted_spectrum_scatter_accumulate.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_spectrum_scatter_accumulate
// Weighted nearest-channel accumulation of spectrum samples into a cube.
// ----------------------------------------------------------------------------
// An accepted item passes the front register, then the back's store read-modify-write
// sequence (issue, read, multiply, accumulate and write, deliver) into the result
// register; the back takes no new item until that sequence has ended.
// Reset: after rst_ni rises, a clearing pass over all CUBE_DEPTH cells zeroes the
// stores; items wait during it, configuration writes are taken.
module weighted_spectrum_scatter_accumulate #(
  parameter int unsigned CUBE_DEPTH       = wssa_pkg::CubeDepthDef,
  parameter int unsigned MAX_OUT_CHANNELS = wssa_pkg::MaxOutChanDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [2:0]    paddr_i,
  input  logic [31:0]   pwdata_i,
  output logic [31:0]   prdata_o,
  output logic          pready_o,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // tdata: sample[31:0], sample_bad, out_chan[7:0], out_chan_valid,
  // spatial_pos[11:0], weight[15:0], input_variance[31:0], cell_addr[11:0]
  input  logic [119:0]  s_axis_tdata_i,
  input  logic          s_axis_tlast_i,
  // tuser: func
  input  logic          s_axis_tuser_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // tdata: data_sum, weight_sum, var_sum, square_sum, used_count[39:0]
  output logic [231:0]  m_axis_tdata_o,
  // tuser: spectrum_used, addr_error
  output logic [1:0]    m_axis_tuser_o
);
  import wssa_pkg::*;
  localparam int unsigned AW = $clog2(CUBE_DEPTH);
  localparam logic [2:0] AddrMode  = 3'd0;
  localparam logic [2:0] AddrPlane = 3'd4;

  logic [1:0]  var_mode_q;
  logic [12:0] plane_q;
  item_t       item;
  result_t     res;
  logic        qv, qr, quse, qerr;
  item_t       qitem;
  logic [AW-1:0] qcell;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      var_mode_q <= ModeNone;
      plane_q    <= PlaneReset;
    end else if (psel_i && penable_i && pwrite_i && pready_o) begin
      if (paddr_i == AddrMode)  var_mode_q <= pwdata_i[1:0];
      if (paddr_i == AddrPlane) plane_q    <= pwdata_i[12:0];
    end
  end
  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i == AddrMode)  ? 32'(var_mode_q) :
                    (paddr_i == AddrPlane) ? 32'(plane_q) : 32'd0;

  // unpack input
  assign item.func           = s_axis_tuser_i;
  assign item.sample         = s_axis_tdata_i[31:0];
  assign item.sample_bad     = s_axis_tdata_i[32];
  assign item.out_chan       = s_axis_tdata_i[40:33];
  assign item.out_chan_valid = s_axis_tdata_i[41];
  assign item.spatial_pos    = s_axis_tdata_i[53:42];
  assign item.weight         = s_axis_tdata_i[69:54];
  assign item.input_variance = s_axis_tdata_i[101:70];
  assign item.last           = s_axis_tlast_i;
  assign item.cell_addr      = s_axis_tdata_i[113:102];

  wssa_front #(.CubeDepth(CUBE_DEPTH), .MaxOutChan(MAX_OUT_CHANNELS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_ready_o(s_axis_tready_o), .item_i(item),
    .plane_size_i(plane_q),
    .q_valid_o(qv), .q_ready_i(qr), .q_item_o(qitem), .q_cell_o(qcell),
    .q_use_o(quse), .q_err_o(qerr));

  wssa_back #(.CubeDepth(CUBE_DEPTH)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(qv), .q_ready_o(qr), .q_item_i(qitem), .q_cell_i(qcell),
    .q_use_i(quse), .q_err_i(qerr), .var_mode_i(var_mode_q),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i), .out_o(res));

  assign m_axis_tdata_o = {res.used_count, res.square_sum, res.var_sum,
                           res.weight_sum, res.data_sum};
  assign m_axis_tuser_o = {res.addr_error, res.spectrum_used};
endmodule

// ===== tb/weighted_spectrum_scatter_accumulate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_spectrum_scatter_accumulate_tb
// Drives spectra of paste transactions and cell reads through the stream
// port and changes var_mode and plane_size over APB between phases. A
// cube-accumulation predictor computes each expected used flag, error flag,
// counter and cell sum set, and every output transaction is checked against
// it, field by field.
// ----------------------------------------------------------------------------
module weighted_spectrum_scatter_accumulate_tb;
  import wssa_pkg::*;

  localparam int unsigned Depth     = 4096;
  localparam logic        FuncPaste = 1'b0;
  localparam logic        FuncRead  = 1'b1;
  localparam logic [2:0]  AddrMode  = 3'd0;
  localparam logic [2:0]  AddrPlane = 3'd4;
  localparam logic [1:0]  ModeSpare = 2'd3;
  localparam int unsigned DrainWait = 40;
  localparam int unsigned CycleLimit = 600000;
  localparam logic [47:0] UMax48 = 48'hFFFF_FFFF_FFFF;
  localparam longint      SMax48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint      SMin48 = -64'sh0000_8000_0000_0000;

  // Cube accumulation predictor and queue of pending output transactions
  class cube_scoreboard;
    logic signed [47:0] data_mem[Depth];
    logic [47:0]        wsum_mem[Depth];
    logic [47:0]        vsum_mem[Depth];
    logic [47:0]        sq_mem[Depth];
    logic [39:0]        used_cnt;
    logic               used_flag;
    logic               err_flag;
    logic [1:0]         mode;
    logic [12:0]        plane;
    result_t            pending[$];
    int                 errors;

    function new();
      for (int i = 0; i < Depth; i++) begin
        data_mem[i] = '0;
        wsum_mem[i] = '0;
        vsum_mem[i] = '0;
        sq_mem[i]   = '0;
      end
      used_cnt = '0;
      used_flag = 1'b0;
      err_flag = 1'b0;
      mode = ModeNone;
      plane = PlaneReset;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] addr, logic [31:0] value);
      if (addr == AddrMode) mode = value[1:0];
      else if (addr == AddrPlane) plane = value[12:0];
    endfunction

    function logic [47:0] add_usat(logic [47:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {17'd0, a} + {1'b0, b};
      return (s > {17'd0, UMax48}) ? UMax48 : s[47:0];
    endfunction

    // Accumulate one sample into its cube location
    function void paste(item_t it);
      longint      s, acc;
      logic [63:0] w, cidx, mag, s2, hi, lo;
      if (it.sample_bad || !it.out_chan_valid) return;
      s = longint'(it.sample);
      w = {48'd0, it.weight};
      cidx = {52'd0, it.spatial_pos} + {56'd0, it.out_chan} * {51'd0, plane};
      if (cidx >= Depth) begin
        err_flag = 1'b1;
        return;
      end
      used_flag = 1'b1;
      acc = longint'(data_mem[cidx]) + s * longint'(w);
      if (acc > SMax48) acc = SMax48;
      if (acc < SMin48) acc = SMin48;
      data_mem[cidx] = acc[47:0];
      wsum_mem[cidx] = add_usat(wsum_mem[cidx], w);
      used_cnt = used_cnt + 40'd1;
      if (mode == ModeInVar) begin
        vsum_mem[cidx] = add_usat(vsum_mem[cidx],
                                  (w * w * {32'd0, it.input_variance}) >> 16);
      end else if (mode == ModeSpread) begin
        vsum_mem[cidx] = add_usat(vsum_mem[cidx], w * w);
        mag = (s < 0) ? -s : s;
        s2 = mag * mag;
        hi = (s2 >> 32) * w;
        lo = (s2 & 64'hFFFF_FFFF) * w;
        sq_mem[cidx] = add_usat(sq_mem[cidx], (hi << 8) + (lo >> 24));
      end
    endfunction

    // Note an accepted input transaction
    function void note_item(item_t it);
      result_t r;
      r = '0;
      if (it.func == FuncRead) begin
        r.data_sum   = data_mem[it.cell_addr];
        r.weight_sum = wsum_mem[it.cell_addr];
        r.var_sum    = vsum_mem[it.cell_addr];
        r.square_sum = sq_mem[it.cell_addr];
      end else begin
        paste(it);
        if (!it.last) return;
      end
      r.spectrum_used = used_flag;
      r.used_count    = used_cnt;
      r.addr_error    = err_flag;
      pending.push_back(r);
      if (it.func == FuncPaste) begin
        used_flag = 1'b0;
        err_flag = 1'b0;
      end
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    // Check one output transaction against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected output: expected none, actual %h", $time, got);
        return;
      end
      want = pending.pop_front();
      cmp("data_sum", 64'(want.data_sum), 64'(got.data_sum));
      cmp("weight_sum", 64'(want.weight_sum), 64'(got.weight_sum));
      cmp("var_sum", 64'(want.var_sum), 64'(got.var_sum));
      cmp("square_sum", 64'(want.square_sum), 64'(got.square_sum));
      cmp("spectrum_used", 64'(want.spectrum_used), 64'(got.spectrum_used));
      cmp("used_count", 64'(want.used_count), 64'(got.used_count));
      cmp("addr_error", 64'(want.addr_error), 64'(got.addr_error));
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          psel_i = 1'b0, penable_i = 1'b0, pwrite_i = 1'b0;
  logic [2:0]    paddr_i = '0;
  logic [31:0]   pwdata_i = '0;
  logic [31:0]   prdata_o;
  logic          pready_o;
  logic          s_axis_tvalid_i = 1'b0;
  logic          s_axis_tready_o;
  // tdata: sample, sample_bad, out_chan, out_chan_valid, spatial_pos, weight,
  // input_variance, cell_addr (low bits up)
  logic [119:0]  s_axis_tdata_i = '0;
  logic          s_axis_tlast_i = 1'b0;
  // tuser: func
  logic          s_axis_tuser_i = 1'b0;
  logic          m_axis_tvalid_o;
  logic          m_axis_tready_i = 1'b0;
  // tdata: data_sum, weight_sum, var_sum, square_sum, used_count (low bits up)
  logic [231:0]  m_axis_tdata_o;
  // tuser: spectrum_used, addr_error
  logic [1:0]    m_axis_tuser_o;

  cube_scoreboard sb = new();
  int unsigned    send_idle = 0;
  int unsigned    recv_stall = 0;
  int unsigned    cycles = 0;
  logic [63:0]    last_cell = '0;

  weighted_spectrum_scatter_accumulate dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: check accepted transactions, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      result_t got;
      got.data_sum      = m_axis_tdata_o[47:0];
      got.weight_sum    = m_axis_tdata_o[95:48];
      got.var_sum       = m_axis_tdata_o[143:96];
      got.square_sum    = m_axis_tdata_o[191:144];
      got.used_count    = m_axis_tdata_o[231:192];
      got.spectrum_used = m_axis_tuser_o[0];
      got.addr_error    = m_axis_tuser_o[1];
      sb.check_result(got);
    end
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send_item(item_t it);
    logic [119:0] packed_v;
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    packed_v = {6'd0, it.cell_addr, it.input_variance, it.weight, it.spatial_pos,
                it.out_chan_valid, it.out_chan, it.sample_bad, it.sample};
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= packed_v;
    s_axis_tlast_i  <= it.last;
    s_axis_tuser_i  <= it.func;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_item(it);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] value);
    @(posedge clk_i);
    psel_i <= 1'b1;
    pwrite_i <= 1'b1;
    paddr_i <= addr;
    pwdata_i <= value;
    @(posedge clk_i);
    penable_i <= 1'b1;
    @(posedge clk_i);
    psel_i <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i <= 1'b0;
    sb.set_reg(addr, value);
  endtask

  // Pause the sender until the block has gone quiet
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic item_t paste_item(logic [11:0] pos, logic [7:0] chan, logic last);
    item_t it;
    it = '0;
    it.func = FuncPaste;
    it.sample = $urandom;
    it.sample_bad = ($urandom_range(9) == 0);
    it.out_chan = chan;
    it.out_chan_valid = ($urandom_range(9) != 0);
    it.spatial_pos = pos;
    it.weight = 16'($urandom);
    it.input_variance = $urandom;
    it.last = last;
    it.cell_addr = 12'($urandom);
    return it;
  endfunction

  function automatic item_t read_item(logic [11:0] addr);
    item_t it;
    it = '0;
    it.func = FuncRead;
    it.cell_addr = addr;
    it.spatial_pos = addr;
    it.sample = $urandom;
    it.last = 1'($urandom);
    return it;
  endfunction

  // One random spectrum with reads mixed in; a few pure-noise transactions
  task automatic random_spectrum(inout int unsigned sent);
    int unsigned  len;
    logic [11:0]  pos;
    logic [15:0]  w;
    logic [31:0]  iv;
    logic [127:0] noise;
    item_t it;
    len = $urandom_range(12, 1);
    pos = (sb.plane > 256) ? 12'($urandom_range(255)) : 12'($urandom);
    w = 16'($urandom);
    iv = $urandom;
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(99) < 12) begin
        it = read_item(($urandom_range(1)) ? last_cell[11:0] : 12'($urandom));
      end else if ($urandom_range(99) < 4) begin
        noise = {$urandom, $urandom, $urandom, $urandom};
        it = noise[$bits(item_t)-1:0];
        if (it.func == FuncRead) it.spatial_pos = it.cell_addr;
      end else begin
        it = paste_item(pos, (sb.plane > 16) ? 8'($urandom_range(7)) : 8'($urandom),
                        k == len - 1);
        it.weight = w;
        it.input_variance = iv;
        last_cell = {52'd0, pos} + {56'd0, it.out_chan} * {51'd0, sb.plane};
      end
      send_item(it);
      sent++;
    end
  endtask

  // Directed transactions: extremes, saturation, bad and unmapped samples
  task automatic directed();
    item_t it;
    it = paste_item(12'd5, 8'd0, 1'b0);
    it.sample = 32'sh7FFF_FFFF; it.weight = 16'hFFFF; it.input_variance = 32'hFFFF_FFFF;
    it.sample_bad = 1'b0; it.out_chan_valid = 1'b1;
    repeat (3) send_item(it);
    it.last = 1'b1;
    send_item(it);
    send_item(read_item(12'd5));
    it.sample = 32'sh8000_0000; it.spatial_pos = 12'd6; it.last = 1'b0;
    repeat (4) send_item(it);
    it.sample_bad = 1'b1; it.last = 1'b1;
    send_item(it);
    send_item(read_item(12'd6));
    it.sample_bad = 1'b0; it.out_chan_valid = 1'b0; it.spatial_pos = 12'd7;
    send_item(it);
    send_item(read_item(12'd7));
    // channel beyond the cube
    it.out_chan_valid = 1'b1; it.out_chan = 8'hFF; it.spatial_pos = 12'hFFF;
    it.last = 1'b0;
    send_item(it);
    it.out_chan = 8'd0; it.sample = '0; it.weight = '0; it.input_variance = '0;
    it.last = 1'b1;
    send_item(it);
    send_item(read_item(12'hFFF));
    send_item(read_item(12'd0));
  endtask

  initial begin
    logic [1:0]  modes[8];
    logic [12:0] planes[8];
    int unsigned sent;
    modes  = '{ModeNone, ModeSpread, ModeInVar, ModeSpare, ModeInVar, ModeSpread,
               ModeInVar, ModeSpread};
    planes = '{13'd64, 13'd16, 13'd4096, 13'd0, 13'd1, 13'd8191, 13'd3, 13'd64};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    directed();
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        apb_write(AddrMode, {30'd0, modes[ph]});
        apb_write(AddrPlane, {19'd0, planes[ph]});
      end
      send_idle  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 55 : 25) : 0;
      recv_stall = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 55 : 25) : 0;
      sent = 0;
      while (sent < 235) begin
        random_spectrum(sent);
        if (ph == 2 && sent >= 100 && sent < 112) drain();
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
